>>> rtl/core/u2u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants, surrogate tests and UTF-8 byte functions of the
// UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam logic [15:0] HIGH_MIN    = 16'hD800;
	localparam logic [15:0] HIGH_MAX    = 16'hDBFF;
	localparam logic [15:0] LOW_MIN     = 16'hDC00;
	localparam logic [15:0] LOW_MAX     = 16'hDFFF;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam int          PAIR_SHIFT  = 10;

	localparam int CP_W = 21;

	// utf8 sequence length minus one
	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} utf8_len_t;

	typedef struct packed {
		logic [15:0] utf16_unit;
		logic        end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       last_of_run;
		logic       string_done;
	} out_item_t;

	// Work for the byte encoder: an optional lone surrogate that was held,
	// then an optional code point of the current unit.
	typedef struct packed {
		logic              eos;
		logic              first_v;
		logic [15:0]       first_cp;
		logic              second_v;
		logic [CP_W-1:0]   second_cp;
	} job_t;

	function automatic logic is_high(input logic [15:0] u);
		return (u >= HIGH_MIN) && (u <= HIGH_MAX);
	endfunction

	function automatic logic is_low(input logic [15:0] u);
		return (u >= LOW_MIN) && (u <= LOW_MAX);
	endfunction

	function automatic utf8_len_t utf8_len(input logic [CP_W-1:0] cp);
		utf8_len_t len;
		if (cp < 21'h80) begin
			len = LEN_1;
		end else if (cp < 21'h800) begin
			len = LEN_2;
		end else if (cp < SUPP_BASE) begin
			len = LEN_3;
		end else begin
			len = LEN_4;
		end
		return len;
	endfunction

	function automatic logic [7:0] utf8_byte_at(input logic [CP_W-1:0] cp,
			input utf8_len_t len, input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			LEN_1: b = {1'b0, cp[6:0]};
			LEN_2: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
				else             b = {2'b10, cp[5:0]};
			end
			LEN_3: begin
				unique case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_4: begin
				unique case (idx)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					2'd3: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/utf16_to_utf8_transcoder.sv
`default_nettype none
// Takes UTF-16 code units at up to one per cycle and delivers UTF-8 bytes at one
// per cycle while jobs are queued and the result is popped. An item yields no
// byte for a held high surrogate, 1 to 4 bytes for one code point and up to 6
// when a held surrogate is flushed as lone before the new unit; the back end has
// a single byte encoder. The front end takes a new request every cycle while the
// job queue (JOB_DEPTH entries) has room, and the first byte of a request passes
// the job queue and then the output register before it is on the result ports.
// allow_invalid is read when a unit is accepted.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and
// optional replacement of lone surrogates.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder import u2u8_pkg::*; #(
	parameter int JOB_DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_wen,
	input  wire logic      cfg_wdata,
	input  wire logic      push,
	output logic           full,
	input  wire in_item_t  in_data,
	output logic           empty,
	input  wire logic      pop,
	output out_item_t      out_data
);

	logic allow_invalid_q;
	logic job_push;
	job_t job_in;
	logic job_full;
	job_t job_head;
	logic job_empty;
	logic job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_invalid_q <= 1'b0;
		end else if (cfg_wen) begin
			allow_invalid_q <= cfg_wdata;
		end
	end

	u2u8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.allow_invalid (allow_invalid_q),
		.push          (push),
		.full          (full),
		.in_data       (in_data),
		.job_full      (job_full),
		.job_push      (job_push),
		.job           (job_in)
	);

	u2u8_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_job (job_head),
		.empty  (job_empty)
	);

	u2u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

>>> rtl/core/u2u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, pairs surrogates and turns each request, but a held high
// surrogate, into a job of at most two code points for the byte encoder.
// ----------------------------------------------------------------------------
module u2u8_front import u2u8_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     allow_invalid,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t in_data,
	input  wire logic     job_full,
	output logic          job_push,
	output job_t          job
);

	logic        pend_v_q;
	logic [15:0] pend_q;
	logic        pend_v_d;
	logic [15:0] pend_d;
	logic        accept;
	logic [15:0] cu;
	logic        eos;

	assign full   = job_full;
	assign accept = push & ~job_full;
	assign cu     = in_data.utf16_unit;
	assign eos    = in_data.end_of_string;

	always_comb begin
		job          = '0;
		job.eos      = eos;
		pend_v_d     = 1'b0;
		pend_d       = 16'h0000;
		if (pend_v_q && is_low(cu)) begin
			job.second_v  = 1'b1;
			job.second_cp = SUPP_BASE + {1'b0, pend_q[PAIR_SHIFT-1:0], cu[PAIR_SHIFT-1:0]};
		end else begin
			// flush a held high surrogate as a lone one first
			job.first_v  = pend_v_q;
			job.first_cp = allow_invalid ? pend_q : REPLACEMENT;
			if (is_high(cu) && !eos) begin
				pend_v_d = 1'b1;
				pend_d   = cu;
			end else if (is_high(cu) || is_low(cu)) begin
				job.second_v  = 1'b1;
				job.second_cp = {5'b0, (allow_invalid ? cu : REPLACEMENT)};
			end else begin
				job.second_v  = 1'b1;
				job.second_cp = {5'b0, cu};
			end
		end
	end

	assign job_push = accept & (job.first_v | job.second_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_q   <= 16'h0000;
		end else if (accept) begin
			pend_v_q <= pend_v_d;
			pend_q   <= pend_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/u2u8_jobq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_jobq
// Small register queue of jobs between the front and the byte encoder.
// ----------------------------------------------------------------------------
module u2u8_jobq import u2u8_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_job,
	output logic      full,
	input  wire logic rd_en,
	output job_t      rd_job,
	output logic      empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr_en & ~full;
	assign do_rd  = rd_en & ~empty;
	assign rd_job = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_rd) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/u2u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_back
// Byte encoder: walks the code points of the head job and emits one UTF-8
// byte per cycle into the output register while that register is free or popped.
// ----------------------------------------------------------------------------
module u2u8_back import u2u8_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic job_empty,
	output logic      job_pop,
	input  wire logic pop,
	output logic      empty,
	output out_item_t out_data
);

	logic            out_v_q;
	out_item_t       out_q;
	logic            phase_q;
	logic [1:0]      idx_q;
	logic            cur_first;
	logic [CP_W-1:0] cp;
	utf8_len_t       len;
	logic            byte_last;
	logic            cp_last;
	logic            step;

	assign empty    = ~out_v_q;
	assign out_data = out_q;

	assign cur_first = job.first_v & ~phase_q;
	assign cp        = cur_first ? {5'b0, job.first_cp} : job.second_cp;
	assign len       = utf8_len(cp);
	assign byte_last = (idx_q == 2'(len));
	assign cp_last   = ~(cur_first & job.second_v);
	assign step      = ~job_empty & (~out_v_q | pop);
	assign job_pop   = step & byte_last & cp_last;

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.utf8_byte   <= utf8_byte_at(cp, len, idx_q);
			out_q.last_of_run <= byte_last & cp_last;
			out_q.string_done <= byte_last & cp_last & job.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			phase_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (step) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (step) begin
				if (byte_last) begin
					idx_q   <= 2'd0;
					// advance to the second code point or drop the job
					phase_q <= ~cp_last;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/u2u8_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_checker
// Port-level checks of the transcoder's byte stream.
// ----------------------------------------------------------------------------
module u2u8_checker import u2u8_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_item_t out_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_data))
		else $error("result changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_data.string_done |-> out_data.last_of_run)
		else $error("string_done without last_of_run");

	// a popped lead byte is followed by a continuation byte with no gap
	a_lead_cont: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && out_data.utf8_byte[7:6] == 2'b11
		|=> !empty && out_data.utf8_byte[7:6] == 2'b10)
		else $error("lead byte not followed by continuation");

	a_ascii_next: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !out_data.utf8_byte[7] && !out_data.last_of_run
		|=> !empty && out_data.utf8_byte[7:6] != 2'b10)
		else $error("bad byte after single-byte code point");

endmodule

bind utf16_to_utf8_transcoder u2u8_checker u_chk (.*);
`default_nettype wire
